@@ rtl/core/phsp_pkg.sv @@
// Shared constants and types of the periodic hard-sphere placer.
`default_nettype none

package phsp_pkg;

	localparam int MAX_POINTS  = 1024;
	localparam int COORD_W     = 16;
	localparam int NDIM        = 3;

	localparam int BOX_W       = 16;
	localparam int LIMIT_W     = 16;
	localparam int DIMS_W      = 2;
	localparam int TARGET_W    = 11;
	localparam int ATTEMPT_W   = 8;
	localparam int PLACED_W    = 11;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = $clog2(MAX_POINTS);

	// Difference of two coordinates, then 2*d + L and its magnitude.
	localparam int DIFF_W = COORD_W + 1;
	localparam int XW     = ((COORD_W + 2) > (BOX_W + 1) ? (COORD_W + 2) : (BOX_W + 1)) + 1;
	localparam int MAG_W  = XW - 1;
	localparam int DIV_W  = BOX_W + 1;
	localparam int SQ_W   = 2 * BOX_W;

	// Cycles through one wrap unit and through the whole distance pipeline.
	localparam int WRAP_LAT = MAG_W + 2;
	localparam int DIST_LAT = WRAP_LAT + 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_BOX      = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_LIMIT    = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_DIMS     = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET   = CFG_INDEX_W'(3);
	localparam logic [CFG_INDEX_W-1:0] REG_ATTEMPTS = CFG_INDEX_W'(4);

	// Run states as reported on run_status.
	typedef enum logic [1:0] {
		RUN_PLACING = 2'd0,
		RUN_DONE    = 2'd1,
		RUN_FAILED  = 2'd2
	} run_status_t;

	typedef struct packed {
		logic [BOX_W-1:0]  box_len;
		logic [SQ_W-1:0]   lim_sq;
		logic [DIMS_W-1:0] dims;
	} dist_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/phsp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module phsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/phsp_wrap.sv @@
// Pipelined minimum-image reduction of one coordinate difference.
`default_nettype none

module phsp_wrap (
	input  logic                               clk,
	input  logic signed [phsp_pkg::DIFF_W-1:0] delta,
	input  logic        [phsp_pkg::BOX_W-1:0]  box_len,
	output logic signed [phsp_pkg::BOX_W-1:0]  wrapped
);
	import phsp_pkg::*;

	// One restoring step: remove the divisor shifted to bit sh if it fits.
	function automatic logic [MAG_W-1:0] mod_step(input logic [MAG_W-1:0] r,
			input int sh, input logic [DIV_W-1:0] dv);
		logic [MAG_W-1:0] dext;
		dext = MAG_W'(dv);
		if ((r >> sh) >= dext) begin
			return r - (dext << sh);
		end
		return r;
	endfunction

	logic        [DIV_W-1:0] div;
	logic signed [XW-1:0]    x;
	logic        [MAG_W-1:0] rem_s [0:MAG_W];
	logic                    neg_s [0:MAG_W];
	logic        [DIV_W-1:0] rem_last;
	logic        [DIV_W-1:0] rem_fixed;
	logic signed [DIV_W:0]   centered;

	// The wrapped value is ((2d + L) mod 2L - L) / 2, exact in integers.
	assign div = {box_len, 1'b0};
	assign x   = (XW'(delta) <<< 1) + XW'(signed'({1'b0, box_len}));

	assign rem_last  = rem_s[MAG_W][DIV_W-1:0];
	assign rem_fixed = (neg_s[MAG_W] && (rem_last != '0)) ? (div - rem_last) : rem_last;
	assign centered  = signed'({1'b0, rem_fixed}) - signed'({2'b00, box_len});

	always_ff @(posedge clk) begin
		rem_s[0] <= x[XW-1] ? MAG_W'(-x) : MAG_W'(x);
		neg_s[0] <= x[XW-1];
		for (int k = 0; k < MAG_W; k++) begin
			rem_s[k+1] <= mod_step(rem_s[k], MAG_W - 1 - k, div);
			neg_s[k+1] <= neg_s[k];
		end
		wrapped <= BOX_W'(centered >>> 1);
	end

endmodule

`default_nettype wire

@@ rtl/core/phsp_dist.sv @@
// Distance pipeline: wrapped differences, squares, sum and limit compare.
`default_nettype none

module phsp_dist (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  phsp_pkg::dist_cfg_t                    cfg,
	input  logic                                   in_valid,
	input  logic [phsp_pkg::NDIM*phsp_pkg::COORD_W-1:0] cand_word,
	input  logic [phsp_pkg::NDIM*phsp_pkg::COORD_W-1:0] stored_word,
	output logic                                   out_valid,
	output logic                                   out_close,
	output logic                                   busy
);
	import phsp_pkg::*;

	logic [DIST_LAT-1:0]     vld_q;
	logic signed [DIFF_W-1:0] delta_s1 [NDIM];
	logic signed [BOX_W-1:0]  wrap_w   [NDIM];
	logic        [SQ_W-1:0]   sq_s2    [NDIM];
	logic        [SQ_W-1:0]   sum;
	logic                     close_s3;

	for (genvar j = 0; j < NDIM; j++) begin : g_dim
		logic signed [SQ_W-1:0] wx;
		logic                   dim_en;

		assign wx     = SQ_W'(wrap_w[j]);
		assign dim_en = (j < int'(cfg.dims));

		always_ff @(posedge clk) begin
			delta_s1[j] <= DIFF_W'(signed'(cand_word[j*COORD_W +: COORD_W]))
				- DIFF_W'(signed'(stored_word[j*COORD_W +: COORD_W]));
			sq_s2[j] <= dim_en ? unsigned'(wx * wx) : '0;
		end

		phsp_wrap u_wrap (
			.clk     (clk),
			.delta   (delta_s1[j]),
			.box_len (cfg.box_len),
			.wrapped (wrap_w[j])
		);
	end

	// At most three squares each below 2^(SQ_W-2), so the sum cannot overflow.
	assign sum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk) begin
		close_s3 <= (sum < cfg.lim_sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DIST_LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[DIST_LAT-1];
	assign out_close = close_s3;
	assign busy      = |vld_q;

endmodule

`default_nettype wire

@@ rtl/core/periodic_hard_sphere_placer_top.sv @@
// Top level of the periodic hard-sphere placer: registers, sequencer and point store.
`default_nettype none

// Usage. A candidate word (cand_x, cand_y, cand_z, signed Q7.8) is taken at a
// rising clock edge where start is high and busy is low. While placing, the
// block reads every stored point from the point memory, one per cycle, and
// streams it through the distance pipeline, which wraps each coordinate
// difference into the periodic box, squares, sums and compares the result with
// the squared limit distance. When the last comparison has left the pipeline,
// the candidate is either written into the memory or counted as a rejection.
// The result word (accepted, run_status, placed_count, reject_count) is then
// shown for exactly one cycle with done high; the receiver cannot stall it.
// The wait for the result is set by the single read port of the point
// memory, which feeds one stored point per cycle, and by the depth of the
// distance pipeline; once the run has finished, the scan is skipped.
// One candidate is worked on at a time: no new word is taken until the
// result of the last one has been shown.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle; unknown indexes are ignored. Reset clears the counters and
// the run state and restores the register defaults. The memory is not
// cleared: only entries below the stored count are ever read.
module periodic_hard_sphere_placer_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [phsp_pkg::COORD_W-1:0]    cand_x,
	input  logic signed [phsp_pkg::COORD_W-1:0]    cand_y,
	input  logic signed [phsp_pkg::COORD_W-1:0]    cand_z,
	input  logic                                   cfg_we,
	input  logic        [phsp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic        [phsp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                   done,
	output logic                                   accepted,
	output logic        [1:0]                      run_status,
	output logic        [phsp_pkg::PLACED_W-1:0]   placed_count,
	output logic        [phsp_pkg::ATTEMPT_W-1:0]  reject_count
);
	import phsp_pkg::*;

	localparam int TW = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	// Configuration registers.
	logic [BOX_W-1:0]     box_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [DIMS_W-1:0]    dims_q;
	logic [TARGET_W-1:0]  target_q;
	logic [ATTEMPT_W-1:0] max_att_q;
	logic [SQ_W-1:0]      lim_sq_q;

	// Sequencer and run state.
	state_t                    state_q;
	run_status_t               run_q;
	logic [CNT_W-1:0]          count_q;
	logic [ATTEMPT_W-1:0]      attempt_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      rd_valid_q;
	logic                      close_q;
	logic [NDIM*COORD_W-1:0]   cand_q;

	// Result word.
	logic                      done_q;
	logic                      acc_q;
	run_status_t               status_q;
	logic [CNT_W-1:0]          placed_q;
	logic [ATTEMPT_W-1:0]      reject_q;

	// Derived values and next state of the run.
	logic [BOX_W-1:0]     box_len;
	logic [DIMS_W-1:0]    dims_eff;
	logic [CNT_W-1:0]     target_eff;
	logic [ATTEMPT_W-1:0] limit_eff;
	logic                 fits;
	logic [CNT_W-1:0]     count_inc;
	logic [ATTEMPT_W-1:0] attempt_inc;
	logic [CNT_W-1:0]     nxt_count;
	logic [ATTEMPT_W-1:0] nxt_attempt;
	run_status_t          nxt_run;
	logic                 nxt_acc;
	logic                 store_now;
	logic                 rd_en;

	dist_cfg_t               dcfg;
	logic [NDIM*COORD_W-1:0] rd_data;
	logic                    dist_valid;
	logic                    dist_close;
	logic                    dist_busy;

	// Zero settings act as one; a target beyond the store saturates.
	assign box_len    = (box_q == '0) ? BOX_W'(1) : box_q;
	assign dims_eff   = (dims_q == '0) ? DIMS_W'(1) : dims_q;
	assign limit_eff  = (max_att_q == '0) ? ATTEMPT_W'(1) : max_att_q;
	assign target_eff = (target_q == '0) ? CNT_W'(1) :
		(TW'(target_q) > TW'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(target_q);

	assign dcfg.box_len = box_len;
	assign dcfg.lim_sq  = lim_sq_q;
	assign dcfg.dims    = dims_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q     <= BOX_W'(2560);
			limit_q   <= LIMIT_W'(256);
			dims_q    <= DIMS_W'(3);
			target_q  <= TARGET_W'(100);
			max_att_q <= ATTEMPT_W'(250);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX:      box_q     <= BOX_W'(cfg_data);
				REG_LIMIT:    limit_q   <= LIMIT_W'(cfg_data);
				REG_DIMS:     dims_q    <= DIMS_W'(cfg_data);
				REG_TARGET:   target_q  <= TARGET_W'(cfg_data);
				REG_ATTEMPTS: max_att_q <= ATTEMPT_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// The squared limit is only needed deep in the distance pipeline, so a
	// register after the multiply costs nothing in latency.
	always_ff @(posedge clk) begin
		lim_sq_q <= SQ_W'(limit_q) * SQ_W'(limit_q);
	end

	// Decision taken once every stored point has been compared.
	assign fits        = !close_q && (count_q < CNT_W'(MAX_POINTS));
	assign count_inc   = count_q + CNT_W'(1);
	assign attempt_inc = attempt_q + ATTEMPT_W'(1);

	always_comb begin
		nxt_count   = count_q;
		nxt_attempt = attempt_q;
		nxt_run     = run_q;
		nxt_acc     = 1'b0;
		if (run_q == RUN_PLACING) begin
			if (fits) begin
				nxt_count   = count_inc;
				nxt_attempt = '0;
				nxt_acc     = 1'b1;
				if (count_inc >= target_eff) begin
					nxt_run = RUN_DONE;
				end
			end else begin
				nxt_attempt = attempt_inc;
				if (attempt_inc >= limit_eff) begin
					// The store is emptied on the failing word itself.
					nxt_count = '0;
					nxt_run   = RUN_FAILED;
				end
			end
		end
	end

	assign store_now = (state_q == ST_DECIDE) && nxt_acc;
	assign rd_en     = (state_q == ST_SCAN) && (idx_q != count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_q      <= RUN_PLACING;
			count_q    <= '0;
			attempt_q  <= '0;
			idx_q      <= '0;
			rd_valid_q <= 1'b0;
			close_q    <= 1'b0;
			done_q     <= 1'b0;
			acc_q      <= 1'b0;
			status_q   <= RUN_PLACING;
			placed_q   <= '0;
			reject_q   <= '0;
		end else begin
			done_q     <= (state_q == ST_DECIDE);
			rd_valid_q <= rd_en;
			if (dist_valid && dist_close) begin
				close_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						close_q <= 1'b0;
						state_q <= (run_q == RUN_PLACING) ? ST_SCAN : ST_DECIDE;
					end
				end
				ST_SCAN: begin
					if (idx_q == count_q) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_q && !dist_busy) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					count_q   <= nxt_count;
					attempt_q <= nxt_attempt;
					run_q     <= nxt_run;
					acc_q     <= nxt_acc;
					status_q  <= nxt_run;
					placed_q  <= nxt_count;
					reject_q  <= nxt_attempt;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The candidate needs no reset; it is loaded with every word taken at start.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			cand_q <= {cand_z, cand_y, cand_x};
		end
	end

	phsp_ram #(
		.WIDTH (NDIM * COORD_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (store_now),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (cand_q),
		.re    (rd_en),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	phsp_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (dcfg),
		.in_valid    (rd_valid_q),
		.cand_word   (cand_q),
		.stored_word (rd_data),
		.out_valid   (dist_valid),
		.out_close   (dist_close),
		.busy        (dist_busy)
	);

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign accepted     = acc_q;
	assign run_status   = status_q;
	assign placed_count = PLACED_W'(placed_q);
	assign reject_count = reject_q;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench of the periodic hard-sphere placer top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import phsp_pkg::*;

	// One candidate word as it goes onto cand_x, cand_y and cand_z.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} cand_t;

	// One result word as it should come back.
	typedef struct packed {
		logic                 acc;
		logic [1:0]           status;
		logic [PLACED_W-1:0]  placed;
		logic [ATTEMPT_W-1:0] rejects;
	} outcome_t;

	localparam int RANDOM_ITEMS = 555;
	// The slowest correct run is bounded by its few hundred words, each waiting
	// at most a full store scan plus the pipeline and the longest sender gap.
	// The watchdog limit allows several times that.
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int END_DRAIN    = 64;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic signed [COORD_W-1:0]     cand_x;
	logic signed [COORD_W-1:0]     cand_y;
	logic signed [COORD_W-1:0]     cand_z;
	logic                          cfg_we;
	logic        [CFG_INDEX_W-1:0] cfg_index;
	logic        [CFG_DATA_W-1:0]  cfg_data;
	logic                          done;
	logic                          accepted;
	logic        [1:0]             run_status;
	logic        [PLACED_W-1:0]    placed_count;
	logic        [ATTEMPT_W-1:0]   reject_count;

	periodic_hard_sphere_placer_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cand_x       (cand_x),
		.cand_y       (cand_y),
		.cand_z       (cand_z),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.accepted     (accepted),
		.run_status   (run_status),
		.placed_count (placed_count),
		.reject_count (reject_count)
	);

	// Shadow copy of the configuration registers, at their register widths.
	logic [BOX_W-1:0]     box_reg;
	logic [LIMIT_W-1:0]   limit_reg;
	logic [DIMS_W-1:0]    dims_reg;
	logic [TARGET_W-1:0]  target_reg;
	logic [ATTEMPT_W-1:0] attempts_reg;

	// Shadow copy of the placement state.
	longint      stored_pt [MAX_POINTS][NDIM];
	int          n_placed;
	int          n_rejects;
	run_status_t run_st;

	// Candidate words waiting to be driven and result words still owed.
	cand_t      cand_q[$];
	outcome_t   outcome_q[$];

	int         n_errors;
	int         n_queued;
	int         burst_left;
	int         gap_left;
	int         cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Minimum-image separation along one axis: d - floor((2d + L) / (2L)) * L.
	// The division has to round toward minus infinity, so the truncating
	// quotient is corrected for negative numerators with a remainder.
	function automatic longint wrap_sep(input longint d, input longint len);
		longint num;
		longint den;
		longint q;
		num = 2 * d + len;
		den = 2 * len;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return d - q * len;
	endfunction

	// Works out the result word of one candidate and advances the shadow state.
	function automatic outcome_t place_candidate(input logic signed [COORD_W-1:0] cx,
			input logic signed [COORD_W-1:0] cy, input logic signed [COORD_W-1:0] cz);
		outcome_t r;
		longint   len;
		longint   lim_sq;
		longint   sq;
		longint   w;
		longint   c [NDIM];
		int       dims;
		int       target;
		int       limit;
		bit       clear;
		r = '0;
		if (run_st == RUN_PLACING) begin
			// Zero box, zero dimensions, zero target and zero attempt limit
			// all behave as one; a target beyond the store saturates.
			len = (box_reg == 0) ? 1 : longint'(box_reg);
			dims = (dims_reg == 0) ? 1 : int'(dims_reg);
			target = (target_reg == 0) ? 1 : int'(target_reg);
			if (target > MAX_POINTS)
				target = MAX_POINTS;
			limit = (attempts_reg == 0) ? 1 : int'(attempts_reg);
			lim_sq = longint'(limit_reg) * longint'(limit_reg);
			c[0] = cx;
			c[1] = cy;
			c[2] = cz;
			clear = 1'b1;
			for (int i = 0; i < n_placed && clear; i++) begin
				sq = 0;
				for (int d = 0; d < dims; d++) begin
					w = wrap_sep(c[d] - stored_pt[i][d], len);
					sq += w * w;
				end
				if (sq < lim_sq)
					clear = 1'b0;
			end
			if (clear && n_placed < MAX_POINTS) begin
				for (int d = 0; d < NDIM; d++)
					stored_pt[n_placed][d] = c[d];
				n_placed++;
				n_rejects = 0;
				r.acc = 1'b1;
				if (n_placed >= target)
					run_st = RUN_DONE;
			end else begin
				n_rejects++;
				if (n_rejects >= limit) begin
					n_placed = 0;
					run_st = RUN_FAILED;
				end
			end
		end
		r.status = run_st;
		r.placed = n_placed[PLACED_W-1:0];
		r.rejects = n_rejects[ATTEMPT_W-1:0];
		return r;
	endfunction

	// Builds one candidate from the current configuration and store. Most are
	// inside the box, some sit right at the limit distance from a stored
	// point, and the rest are raw bit patterns over the full word.
	function automatic cand_t make_candidate();
		cand_t c;
		int    len;
		int    dims;
		int    pick;
		int    j;
		int    axis;
		int    off;
		int    v [NDIM];
		len = (box_reg == 0) ? 1 : int'(box_reg);
		dims = (dims_reg == 0) ? 1 : int'(dims_reg);
		pick = $urandom_range(0, 9);
		if (pick < 6 || n_placed == 0) begin
			for (int d = 0; d < NDIM; d++)
				v[d] = int'($urandom_range(0, len - 1)) - len / 2;
		end else if (pick < 9) begin
			j = $urandom_range(0, n_placed - 1);
			for (int d = 0; d < NDIM; d++)
				v[d] = int'(stored_pt[j][d]);
			axis = $urandom_range(0, dims - 1);
			off = int'(limit_reg) - 1 + int'($urandom_range(0, 2));
			if ($urandom_range(0, 1) == 1)
				off = -off;
			v[axis] += off;
		end else begin
			for (int d = 0; d < NDIM; d++)
				v[d] = int'($urandom());
		end
		c.x = COORD_W'(v[0]);
		c.y = COORD_W'(v[1]);
		c.z = COORD_W'(v[2]);
		return c;
	endfunction

	function automatic cand_t fixed_cand(input int x, input int y, input int z);
		cand_t c;
		c.x = COORD_W'(x);
		c.y = COORD_W'(y);
		c.z = COORD_W'(z);
		return c;
	endfunction

	// Writes one register over the configuration port and mirrors it in the
	// shadow copy. Unknown indexes leave the shadow untouched.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BOX:      box_reg = val[BOX_W-1:0];
			REG_LIMIT:    limit_reg = val[LIMIT_W-1:0];
			REG_DIMS:     dims_reg = val[DIMS_W-1:0];
			REG_TARGET:   target_reg = val[TARGET_W-1:0];
			REG_ATTEMPTS: attempts_reg = val[ATTEMPT_W-1:0];
			default: ;
		endcase
	endtask

	// Returns once every queued word has been taken, every result word has come
	// back and the block has dropped busy.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (cand_q.size() != 0 || outcome_q.size() != 0 || start || busy);
	endtask

	task automatic queue_cand(input cand_t c);
		cand_q.insert(cand_q.size(), c);
		n_queued++;
	endtask

	// Driver. A word is taken at an edge where start is high and busy is low;
	// the prediction is made right there so that it sees the same
	// configuration and store as the block. Words go out in bursts, and after
	// the last word of a burst is taken the driver sits out a gap, which can
	// be short or longer than a whole store scan, so the next start lands on
	// any phase of the block's work.
	always @(posedge clk) begin : driver
		cand_t next_cand;
		logic  go;
		if (arst_n) begin
			if (start && !busy)
				outcome_q.insert(outcome_q.size(), place_candidate(cand_x, cand_y, cand_z));
			go = start && busy;
			if (!go) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cand_q.size() > 0) begin
					next_cand = cand_q.pop_front();
					cand_x <= next_cand.x;
					cand_y <= next_cand.y;
					cand_z <= next_cand.z;
					go = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
							: $urandom_range(0, 5);
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
							: $urandom_range(0, 6);
					end
				end
			end
			start <= go;
		end
	end

	// Monitor. Every done cycle carries one result word, which is checked field
	// by field against the oldest prediction.
	always @(posedge clk) begin : monitor
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$error("result word with nothing owed: accepted %0d status %0d placed %0d rejects %0d",
					accepted, run_status, placed_count, reject_count);
				n_errors++;
			end else begin
				want = outcome_q.pop_front();
				if (accepted !== want.acc) begin
					$error("accepted: expected %0d, got %0d", want.acc, accepted);
					n_errors++;
				end
				if (run_status !== want.status) begin
					$error("run_status: expected %0d, got %0d", want.status, run_status);
					n_errors++;
				end
				if (placed_count !== want.placed) begin
					$error("placed_count: expected %0d, got %0d", want.placed, placed_count);
					n_errors++;
				end
				if (reject_count !== want.rejects) begin
					$error("reject_count: expected %0d, got %0d", want.rejects, reject_count);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin : watchdog
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int unsigned len;
		int unsigned lim;
		int          n;
		// Inputs known from time zero, reset defaults in the shadow state.
		arst_n = 1'b0;
		start = 1'b0;
		cand_x = '0;
		cand_y = '0;
		cand_z = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		box_reg = 16'd2560;
		limit_reg = 16'd256;
		dims_reg = 2'd3;
		target_reg = 11'd100;
		attempts_reg = 8'd250;
		n_placed = 0;
		n_rejects = 0;
		run_st = RUN_PLACING;
		n_errors = 0;
		n_queued = 0;
		burst_left = 0;
		gap_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A box of 10.0 and a limit of 1.0 in three dimensions;
		// the target is lifted to the store size so that the run keeps placing.
		write_reg(REG_TARGET, MAX_POINTS);
		write_reg(REG_ATTEMPTS, 255);
		write_reg(REG_BOX, 2560);
		write_reg(REG_LIMIT, 256);
		write_reg(REG_DIMS, 3);
		// Unknown indexes must not disturb any register.
		for (int k = 1; k <= 3; k++)
			write_reg(CFG_INDEX_W'(REG_ATTEMPTS) + CFG_INDEX_W'(k), $urandom());
		queue_cand(fixed_cand(0, 0, 0));             // first point always goes in
		queue_cand(fixed_cand(0, 0, 0));             // exact duplicate
		queue_cand(fixed_cand(256, 0, 0));           // exactly at the limit
		queue_cand(fixed_cand(0, 255, 0));           // just inside the limit
		queue_cand(fixed_cand(-1280, 0, 0));         // on the lower box edge
		queue_cand(fixed_cand(1279, 0, 0));          // neighbor across the wrap
		queue_cand(fixed_cand(-32768, -32768, -32768));
		queue_cand(fixed_cand(32767, 32767, 32767));
		queue_cand(fixed_cand(21845, -21846, 21845));
		queue_cand(fixed_cand(-21846, 21845, -21846));
		wait_idle();
		// One dimension: only x counts, so equal x means a clash.
		write_reg(REG_DIMS, 1);
		queue_cand(fixed_cand(0, 1000, -1000));
		queue_cand(fixed_cand(700, -32768, 32767));
		wait_idle();
		// Zero dimensions behave as one.
		write_reg(REG_DIMS, 0);
		queue_cand(fixed_cand(700, 5, 5));
		queue_cand(fixed_cand(1100, -500, 900));
		wait_idle();
		write_reg(REG_DIMS, 2);
		queue_cand(fixed_cand(900, 900, 0));
		queue_cand(fixed_cand(-640, 640, 32767));
		wait_idle();
		// With no limit distance nothing is rejected, duplicates included; the
		// attempt limit at its floor is harmless then.
		write_reg(REG_LIMIT, 0);
		write_reg(REG_ATTEMPTS, 1);
		queue_cand(fixed_cand(0, 0, 0));
		queue_cand(fixed_cand(0, 0, 0));
		wait_idle();
		write_reg(REG_ATTEMPTS, 255);
		// A zero box acts as a unit box: every separation wraps to nothing.
		write_reg(REG_BOX, 0);
		write_reg(REG_LIMIT, 1);
		queue_cand(fixed_cand(123, -45, 6));
		wait_idle();
		// Largest box with the largest limit rejects everything.
		write_reg(REG_BOX, 65535);
		write_reg(REG_LIMIT, 65535);
		queue_cand(fixed_cand(-32768, 32767, 0));
		wait_idle();
		write_reg(REG_BOX, 1);
		write_reg(REG_LIMIT, 1);
		queue_cand(fixed_cand(4096, 0, -4096));
		wait_idle();

		// Random part, in phases of a few dozen words under one setting each.
		n_queued = 0;
		while (n_queued < RANDOM_ITEMS) begin
			// Keep the rejection streak well clear of the attempt limit so
			// that the run does not fail before the end.
			if (n_rejects > 150) begin
				write_reg(REG_LIMIT, 0);
				queue_cand(make_candidate());
				wait_idle();
			end
			case ($urandom_range(0, 5))
				0:       len = 2560;
				1:       len = $urandom_range(1, 65535);
				2:       len = $urandom_range(256, 4096);
				3:       len = 65535;
				4:       len = $urandom_range(1, 16);
				default: len = 0;
			endcase
			case ($urandom_range(0, 5))
				0:       lim = 0;
				1:       lim = $urandom_range(0, 65535);
				default: lim = (((len == 0) ? 1 : len) >> $urandom_range(2, 6))
					+ $urandom_range(0, 3);
			endcase
			write_reg(REG_BOX, len);
			write_reg(REG_LIMIT, lim);
			write_reg(REG_DIMS, $urandom_range(0, 3));
			case ($urandom_range(0, 2))
				0:       write_reg(REG_TARGET, MAX_POINTS);
				1:       write_reg(REG_TARGET, 2047);     // saturates to the store size
				default: write_reg(REG_TARGET, $urandom_range(n_placed + 70, MAX_POINTS));
			endcase
			write_reg(REG_ATTEMPTS, ($urandom_range(0, 1) == 0) ? 255
				: $urandom_range(n_rejects + 70, 255));
			n = $urandom_range(20, 60);
			repeat (n)
				queue_cand(make_candidate());
			wait_idle();
		end

		// Closing phase: an attempt limit of zero acts as one, so the next
		// rejection fails the run and empties the store. The target at its
		// floor only matters on an acceptance, which cannot happen here.
		write_reg(REG_BOX, 2560);
		write_reg(REG_ATTEMPTS, 0);
		if (n_placed == 0) begin
			write_reg(REG_LIMIT, 0);
			queue_cand(fixed_cand(0, 0, 0));
			wait_idle();
		end
		write_reg(REG_LIMIT, 65535);
		write_reg(REG_TARGET, 1);
		queue_cand(fixed_cand(17, -17, 17));
		// After the failure every word is ignored and the held state repeats.
		queue_cand(fixed_cand(0, 0, 0));
		queue_cand(fixed_cand(-32768, 32767, -1));
		queue_cand(make_candidate());
		wait_idle();

		// Nothing is owed any more; give a stray result word time to show up.
		repeat (END_DRAIN) @(posedge clk);
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/phsp_pkg.sv
rtl/core/phsp_ram.sv
rtl/core/phsp_wrap.sv
rtl/core/phsp_dist.sv
rtl/core/periodic_hard_sphere_placer_top.sv
tb/sv/tb.sv
